FILE: rtl/kst_pkg.sv
// Shared types and codes for the keyed slot table.
`timescale 1ns / 1ps

package kst_pkg;

   localparam int SLOT_COUNT_DEF = 64;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [2:0] ST_NEW      = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_KEPT     = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_RANGE    = 3'd5;
   localparam logic [2:0] ST_EMPTY    = 3'd6;

   localparam logic [3:0] VALUE_KEEP = 4'd1;

   typedef struct packed {
      logic [15:0] key;
      logic [7:0]  subkey;
      logic [3:0]  value;
   } slot_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_DONE
   } state_type;

endpackage

FILE: rtl/kst_if.sv
// Request and response channel interfaces of the keyed slot table.
`timescale 1ns / 1ps

interface kst_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] key;
   logic [7:0]  subkey;
   logic [7:0]  subkey_limit;
   logic [3:0]  entry_value;
   logic [7:0]  slot_index;

   modport source (output valid, opcode, key, subkey, subkey_limit, entry_value, slot_index,
                   input ready);
   modport sink   (input valid, opcode, key, subkey, subkey_limit, entry_value, slot_index,
                   output ready);
endinterface

interface kst_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] read_key;
   logic [7:0]  read_subkey;
   logic [3:0]  read_value;
   logic        read_occupied;

   modport source (output valid, status, read_key, read_subkey, read_value, read_occupied,
                   input ready);
   modport sink   (input valid, status, read_key, read_subkey, read_value, read_occupied,
                   output ready);
endinterface

FILE: rtl/kst_store.sv
// Slot memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module kst_store #(
   parameter int SLOT_COUNT = kst_pkg::SLOT_COUNT_DEF,
   parameter int AW         = $clog2(SLOT_COUNT)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output kst_pkg::slot_type rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  kst_pkg::slot_type wr_data
);

   kst_pkg::slot_type slot_mem_ff [SLOT_COUNT];
   kst_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/kst_ctrl.sv
// Sequencer: slot scan for record, indexed read, fill count and response register.
`timescale 1ns / 1ps

module kst_ctrl #(
   parameter int SLOT_COUNT = kst_pkg::SLOT_COUNT_DEF,
   parameter int AW         = $clog2(SLOT_COUNT),
   parameter int CW         = $clog2(SLOT_COUNT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   kst_req_if.sink           req,
   kst_rsp_if.source         rsp,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  kst_pkg::slot_type rd_data,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output kst_pkg::slot_type wr_data
);

   localparam logic [8:0]    IDX_LIMIT  = 9'(SLOT_COUNT);
   localparam logic [CW-1:0] COUNT_FULL = CW'(SLOT_COUNT);

   kst_pkg::state_type state_ff, state_in;

   logic [15:0]       key_ff, key_in;
   logic [7:0]        subkey_ff, subkey_in;
   logic [3:0]        value_ff, value_in;
   logic [CW-1:0]     count_ff, count_in;   // slots 0..count-1 are occupied
   logic [CW-1:0]     scan_ff, scan_in;
   logic              cmp_v_ff, cmp_v_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [2:0]        res_status_ff, res_status_in;
   kst_pkg::slot_type res_slot_ff, res_slot_in;
   logic              res_occ_ff, res_occ_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   kst_pkg::slot_type rsp_slot_ff, rsp_slot_in;
   logic              rsp_occ_ff, rsp_occ_in;

   logic              out_free;
   logic              match;
   logic [8:0]        idx_ext;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign match    = cmp_v_ff && (rd_data.key == key_ff) && (rd_data.subkey == subkey_ff);
   assign idx_ext  = {1'b0, req.slot_index};

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      subkey_in     = subkey_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      cmp_v_in      = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_occ_in    = res_occ_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_occ_in    = rsp_occ_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '{key: key_ff, subkey: subkey_ff, value: value_ff};
      req.ready     = 1'b0;

      unique case (state_ff)
         kst_pkg::S_IDLE: begin
            req.ready   = 1'b1;
            res_slot_in = '0;
            res_occ_in  = 1'b0;
            if (req.valid) begin
               key_in    = req.key;
               subkey_in = req.subkey;
               value_in  = req.entry_value;
               if (req.opcode == kst_pkg::OP_RECORD) begin
                  if (req.key == 16'd0 || req.subkey > req.subkey_limit) begin
                     res_status_in = kst_pkg::ST_REJECTED;
                     state_in      = kst_pkg::S_DONE;
                  end else begin
                     scan_in  = '0;
                     state_in = kst_pkg::S_SCAN;
                  end
               end else if (idx_ext >= IDX_LIMIT) begin
                  res_status_in = kst_pkg::ST_RANGE;
                  state_in      = kst_pkg::S_DONE;
               end else if (idx_ext >= 9'(count_ff)) begin
                  res_status_in = kst_pkg::ST_EMPTY;
                  state_in      = kst_pkg::S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = req.slot_index[AW-1:0];
                  state_in = kst_pkg::S_READ;
               end
            end
         end

         kst_pkg::S_READ: begin
            res_status_in = kst_pkg::ST_NEW;
            res_slot_in   = rd_data;
            res_occ_in    = 1'b1;
            state_in      = kst_pkg::S_DONE;
         end

         kst_pkg::S_SCAN: begin
            // data of the slot read last cycle is checked before moving on
            if (match) begin
               if (value_ff == kst_pkg::VALUE_KEEP) begin
                  res_status_in = kst_pkg::ST_KEPT;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = cmp_idx_ff;
                  res_status_in = kst_pkg::ST_UPDATED;
               end
               state_in = kst_pkg::S_DONE;
            end else if (scan_ff == count_ff) begin
               if (count_ff == COUNT_FULL) begin
                  res_status_in = kst_pkg::ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = scan_ff[AW-1:0];
                  count_in      = count_ff + 1'b1;
                  res_status_in = kst_pkg::ST_NEW;
               end
               state_in = kst_pkg::S_DONE;
            end else begin
               rd_en      = 1'b1;
               rd_addr    = scan_ff[AW-1:0];
               cmp_v_in   = 1'b1;
               cmp_idx_in = scan_ff[AW-1:0];
               scan_in    = scan_ff + 1'b1;
            end
         end

         kst_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_occ_in    = res_occ_ff;
               state_in      = kst_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = kst_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kst_pkg::S_IDLE;
         count_ff     <= '0;
         cmp_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_v_ff     <= cmp_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      subkey_ff     <= subkey_in;
      value_ff      <= value_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_occ_ff    <= res_occ_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.read_key      = rsp_slot_ff.key;
   assign rsp.read_subkey   = rsp_slot_ff.subkey;
   assign rsp.read_value    = rsp_slot_ff.value;
   assign rsp.read_occupied = rsp_occ_ff;

endmodule

FILE: rtl/keyed_slot_table_insert_update.sv
// Keyed slot table top level: sequencer plus slot memory.
//
// Requests arrive on req_chan (valid/ready); each request produces exactly one
// response on rsp_chan. A transfer happens when valid and ready are both high.
// Record (opcode 0) scans the slot memory from slot 0, one read per cycle,
// and writes the first free slot or the first slot holding the same key and
// subkey; a match with VALUE_KEEP leaves the slot as it is, and a full table
// writes nothing. Occupied slots always form a prefix, so the scan covers
// only the filled slots, at a rate set by the single read port of the slot
// memory; a match ends it early. Rejected records answer without a scan, and
// reads (opcode 1) of an out-of-range or empty slot without a memory read.
// One request is in flight at a time; req ready is high while idle.
// The response sits in an output register; a finished result waits there
// while the receiver stalls, and the next request is still accepted. A
// further result waits internally until the output register frees up.
// Reset (synchronous, active high) clears the fill count, so every slot reads
// as empty at once; no clearing pass is needed.
`timescale 1ns / 1ps

module keyed_slot_table_insert_update #(
   parameter int SLOT_COUNT = kst_pkg::SLOT_COUNT_DEF
) (
   input logic       clock,
   input logic       reset,
   kst_req_if.sink   req_chan,
   kst_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);

   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   kst_pkg::slot_type rd_data;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   kst_pkg::slot_type wr_data;

   kst_ctrl #(
      .SLOT_COUNT (SLOT_COUNT),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   kst_store #(
      .SLOT_COUNT (SLOT_COUNT),
      .AW         (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

FILE: bench/slot_table_checker.sv
// Checker for the keyed slot table: watches both channels, predicts each response, compares.
`timescale 1ns / 1ps

module slot_table_checker #(
   parameter int SLOTS = kst_pkg::SLOT_COUNT_DEF
) (
   input logic clock,
   input logic reset,
   kst_req_if  req_chan,
   kst_rsp_if  rsp_chan,
   output int  fail_count,
   output int  pending
);

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] key;
      logic [7:0]  subkey;
      logic [3:0]  value;
      logic        occupied;
   } table_result_type;

   logic [15:0] slot_key [SLOTS];
   logic [7:0]  slot_sub [SLOTS];
   logic [3:0]  slot_val [SLOTS];
   logic        slot_used[SLOTS];

   table_result_type expected_responses[$];
   int errors = 0;
   int outstanding = 0;

   assign fail_count = errors;
   assign pending    = outstanding;

   // Applies one request to the shadow table and returns the response it should produce.
   function automatic table_result_type predict_access(input logic op, input logic [15:0] key,
                                                       input logic [7:0] subkey,
                                                       input logic [7:0] limit,
                                                       input logic [3:0] value,
                                                       input logic [7:0] index);
      table_result_type r;
      bit               taken;
      int               i;
      r = '0;
      taken = 1'b0;
      if (op == kst_pkg::OP_RECORD) begin
         if (key == 16'd0 || subkey > limit) begin
            r.status = kst_pkg::ST_REJECTED;
         end else begin
            r.status = kst_pkg::ST_FULL;
            for (i = 0; i < SLOTS; i++) begin
               if (!taken && (!slot_used[i] || (slot_key[i] == key && slot_sub[i] == subkey)))
               begin
                  taken = 1'b1;
                  if (slot_used[i] && value == kst_pkg::VALUE_KEEP) begin
                     r.status = kst_pkg::ST_KEPT;
                  end else begin
                     r.status     = slot_used[i] ? kst_pkg::ST_UPDATED : kst_pkg::ST_NEW;
                     slot_key[i]  = key;
                     slot_sub[i]  = subkey;
                     slot_val[i]  = value;
                     slot_used[i] = 1'b1;
                  end
               end
            end
         end
      end else if (int'(index) >= SLOTS) begin
         r.status = kst_pkg::ST_RANGE;
      end else if (!slot_used[index]) begin
         r.status = kst_pkg::ST_EMPTY;
      end else begin
         r.status   = kst_pkg::ST_NEW;
         r.key      = slot_key[index];
         r.subkey   = slot_sub[index];
         r.value    = slot_val[index];
         r.occupied = 1'b1;
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] exp_val,
                                input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_key[i]  = '0;
            slot_sub[i]  = '0;
            slot_val[i]  = '0;
            slot_used[i] = 1'b0;
         end
         expected_responses.delete();
         outstanding = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_responses.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, expected nothing, got status %0d",
                        $time, rsp_chan.status);
            end else begin
               want = expected_responses.pop_front();
               compare_field("status", 16'(want.status), 16'(rsp_chan.status));
               compare_field("read_key", want.key, rsp_chan.read_key);
               compare_field("read_subkey", 16'(want.subkey), 16'(rsp_chan.read_subkey));
               compare_field("read_value", 16'(want.value), 16'(rsp_chan.read_value));
               compare_field("read_occupied", 16'(want.occupied), 16'(rsp_chan.read_occupied));
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_responses.push_back(predict_access(req_chan.opcode, req_chan.key,
                                                        req_chan.subkey, req_chan.subkey_limit,
                                                        req_chan.entry_value,
                                                        req_chan.slot_index));
         outstanding = expected_responses.size();
      end
   end

endmodule

FILE: bench/testbench.sv
// Top of the keyed slot table bench: clock, reset, request stimulus, response stalls, verdict.
`timescale 1ns / 1ps

module testbench;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   tx_idle_pct = 0;
   int   rx_stall_pct = 0;
   logic [15:0] key_pool[16];

   kst_req_if req_chan();
   kst_rsp_if rsp_chan();

   keyed_slot_table_insert_update dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   slot_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   // Leaves valid high after the transfer; the caller lowers it when idling.
   task automatic send_request(input logic op, input logic [15:0] key, input logic [7:0] subkey,
                               input logic [7:0] limit, input logic [3:0] value,
                               input logic [7:0] index);
      req_chan.valid        <= 1'b1;
      req_chan.opcode       <= op;
      req_chan.key          <= key;
      req_chan.subkey       <= subkey;
      req_chan.subkey_limit <= limit;
      req_chan.entry_value  <= value;
      req_chan.slot_index   <= index;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic record_entry(input logic [15:0] key, input logic [7:0] subkey,
                               input logic [7:0] limit, input logic [3:0] value);
      send_request(kst_pkg::OP_RECORD, key, subkey, limit, value, 8'($urandom));
   endtask

   task automatic read_slot(input logic [7:0] index);
      send_request(kst_pkg::OP_READ, 16'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                   index);
   endtask

   task automatic sender_gap();
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   // Mostly pool keys with small subkeys so updates and kept duplicates recur; some noise.
   task automatic random_record(input int pool_keys, input int sub_span);
      logic [15:0] key;
      logic [7:0]  subkey;
      logic [7:0]  limit;
      logic [3:0]  value;
      value = ($urandom_range(0, 3) == 0) ? kst_pkg::VALUE_KEEP : 4'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         key    = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
         subkey = 8'($urandom);
         limit  = 8'($urandom);
      end else begin
         key    = key_pool[$urandom_range(0, pool_keys - 1)];
         subkey = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, sub_span));
         if ($urandom_range(0, 9) == 0)
            limit = subkey;
         else if ($urandom_range(0, 9) == 0)
            limit = 8'($urandom);
         else
            limit = 8'($urandom_range(int'(subkey), 255));
      end
      record_entry(key, subkey, limit, value);
   endtask

   task automatic random_read();
      if ($urandom_range(0, 9) < 7)
         read_slot(8'($urandom_range(0, kst_pkg::SLOT_COUNT_DEF + 2)));
      else
         read_slot(8'($urandom));
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.opcode       <= kst_pkg::OP_RECORD;
      req_chan.key          <= '0;
      req_chan.subkey       <= '0;
      req_chan.subkey_limit <= '0;
      req_chan.entry_value  <= '0;
      req_chan.slot_index   <= '0;
      key_pool[0] = 16'hFFFF;
      key_pool[1] = 16'h0001;
      for (int i = 2; i < 16; i++) key_pool[i] = 16'($urandom_range(1, 65535));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, range edges, rejects, new/kept/updated
      read_slot(8'd0);
      read_slot(8'(kst_pkg::SLOT_COUNT_DEF - 1));
      read_slot(8'(kst_pkg::SLOT_COUNT_DEF));
      read_slot(8'hFF);
      record_entry(16'h0000, 8'h00, 8'hFF, 4'h3);
      record_entry(16'h0001, 8'h08, 8'h07, 4'h2);
      record_entry(16'hFFFF, 8'hFF, 8'hFF, 4'hF);
      record_entry(16'h0001, 8'h00, 8'h00, 4'h0);
      record_entry(16'hFFFF, 8'hFF, 8'hFF, kst_pkg::VALUE_KEEP);
      record_entry(16'hFFFF, 8'hFF, 8'hFF, 4'h5);
      record_entry(16'h0001, 8'h00, 8'h00, kst_pkg::VALUE_KEEP);
      record_entry(16'h0001, 8'h01, 8'h00, 4'h7);
      read_slot(8'd0);
      read_slot(8'd1);
      read_slot(8'd2);
      record_entry(16'h8000, 8'h80, 8'hFF, kst_pkg::VALUE_KEEP);
      read_slot(8'd2);
      record_entry(16'h0001, 8'h00, 8'h00, 4'hA);
      read_slot(8'd1);
      drain_responses();

      // random phases: no idling, sender idle, receiver stall, both, no idling
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin
               tx_idle_pct  = 58;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 58;
            end
            3: begin
               tx_idle_pct  = 24;
               rx_stall_pct = 24;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < 250; n++) begin
            sender_gap();
            if ($urandom_range(0, 9) < 6) begin
               // first phase keeps the pair set small so the table fills gradually
               if (phase == 0)
                  random_record(3, 3);
               else
                  random_record(16, 15);
            end else begin
               random_read();
            end
         end
         drain_responses();
      end

      repeat (kst_pkg::SLOT_COUNT_DEF + 8) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
